FILE: rtl/cfr_pkg.sv
// package for the conductor fresnel reflectance unit
`timescale 1ns / 1ps
package cfr_pkg;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned CosFrac  = 14;
  localparam int unsigned InFracDefault  = 12;
  localparam int unsigned OutFracDefault = 16;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned DivW     = 64;
endpackage

FILE: rtl/cfr_if.sv
// valid/ready channel interfaces for the fresnel unit
`timescale 1ns / 1ps
interface cfr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cos_incidence;
  logic        [15:0] eta_red;
  logic        [15:0] eta_green;
  logic        [15:0] eta_blue;
  logic        [15:0] ext_red;
  logic        [15:0] ext_green;
  logic        [15:0] ext_blue;
  modport source (output valid, cos_incidence, eta_red, eta_green, eta_blue,
                  ext_red, ext_green, ext_blue, input ready);
  modport sink (input valid, cos_incidence, eta_red, eta_green, eta_blue,
                ext_red, ext_green, ext_blue, output ready);
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] refl_red;
  logic [15:0] refl_green;
  logic [15:0] refl_blue;
  modport source (output valid, refl_red, refl_green, refl_blue, input ready);
  modport sink (input valid, refl_red, refl_green, refl_blue, output ready);
endinterface

FILE: rtl/cfr_div.sv
// pipelined restoring fraction divider, one quotient bit per stage
`timescale 1ns / 1ps
module cfr_div #(
  parameter int unsigned QBITS = 17,
  parameter int unsigned W     = 64
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [W-1:0]     num_i,
  input  logic [W-1:0]     den_i,
  output logic [QBITS:0]   quo_o
);
  logic [W-1:0]   r_q [QBITS+1];
  logic [W-1:0]   d_q [QBITS+1];
  logic [QBITS:0] q_q [QBITS+1];

  // stage 0: clamp num to den, integer bit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= den_i;
      if (num_i >= den_i) begin
        r_q[0] <= '0;
        q_q[0] <= (QBITS+1)'(1);
      end else begin
        r_q[0] <= num_i;
        q_q[0] <= '0;
      end
    end
  end

  for (genvar s = 1; s <= QBITS; s++) begin : g_st
    logic [W:0] r2;
    assign r2 = {r_q[s-1], 1'b0};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[s] <= d_q[s-1];
        if (r2 >= {1'b0, d_q[s-1]}) begin
          r_q[s] <= W'(r2 - {1'b0, d_q[s-1]});
          q_q[s] <= {q_q[s-1][QBITS-1:0], 1'b1};
        end else begin
          r_q[s] <= W'(r2);
          q_q[s] <= {q_q[s-1][QBITS-1:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = q_q[QBITS];
endmodule

FILE: rtl/cfr_chan.sv
// one color channel: terms, two quotients, average
`timescale 1ns / 1ps
module cfr_chan #(
  parameter int unsigned IN_FRAC_BITS  = cfr_pkg::InFracDefault,
  parameter int unsigned OUT_FRAC_BITS = cfr_pkg::OutFracDefault
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] c_i,
  input  logic [15:0] eta_i,
  input  logic [15:0] ext_i,
  output logic [15:0] refl_o
);
  import cfr_pkg::*;
  localparam int unsigned RsScale = 2 * IN_FRAC_BITS + CosFrac;
  localparam int unsigned RpFull  = 2 * IN_FRAC_BITS + 2 * CosFrac;
  localparam int unsigned RpShift = (RpFull > 58) ? RpFull - 58 : 0;
  localparam int unsigned RpScale = RpFull - RpShift;
  localparam logic [63:0] RsFloor =
    ((64'd1 << RsScale) + 64'd50000000) / 64'd100000000;
  localparam logic [63:0] RpFloor =
    ((64'd1 << RpScale) + 64'd50000000) / 64'd100000000;
  localparam int unsigned QB = OUT_FRAC_BITS + 1;

  // stage 1: squares and products
  logic [32:0] t0_q;
  logic [31:0] ec_q;
  logic [29:0] cc_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q <= 33'(32'(eta_i) * 32'(eta_i)) + 33'(32'(ext_i) * 32'(ext_i));
      ec_q <= eta_i * 16'(c_i);
      cc_q <= c_i * c_i;
    end
  end

  // stage 2: t0*c^2 in two partial products, s terms
  logic [47:0] tlo_q, thi_q;
  logic [63:0] sa_q, sb_q, sd_q, pb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tlo_q <= 48'(t0_q[15:0]) * 48'(cc_q);
      thi_q <= 48'(t0_q[32:16]) * 48'(cc_q);
      sa_q  <= 64'(t0_q) << CosFrac;
      sb_q  <= (64'(ec_q) << 1) << IN_FRAC_BITS;
      sd_q  <= 64'(cc_q) << (2 * IN_FRAC_BITS - CosFrac);
      pb_q  <= (64'(ec_q) << 1) << (IN_FRAC_BITS + CosFrac - RpShift);
    end
  end

  // stage 3: numerators and floored denominators
  logic [63:0] pa;
  logic [63:0] sn_q, sd2_q, pn_q, pd_q;
  logic [63:0] sad, pad, sden, pden;
  assign pa   = ((64'(thi_q) << 16) + 64'(tlo_q)) >> RpShift;
  assign sad  = sa_q + sd_q;
  assign pad  = pa + (64'd1 << RpScale);
  assign sden = sad + sb_q;
  assign pden = pad + pb_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q  <= (sad >= sb_q) ? sad - sb_q : '0;
      pn_q  <= (pad >= pb_q) ? pad - pb_q : '0;
      sd2_q <= (sden < RsFloor) ? RsFloor : sden;
      pd_q  <= (pden < RpFloor) ? RpFloor : pden;
    end
  end

  logic [QB:0] rs, rp;
  cfr_div #(.QBITS(QB), .W(DivW)) u_div_s (
    .clk_i, .en_i, .num_i(sn_q), .den_i(sd2_q), .quo_o(rs));
  cfr_div #(.QBITS(QB), .W(DivW)) u_div_p (
    .clk_i, .en_i, .num_i(pn_q), .den_i(pd_q), .quo_o(rp));

  // final stage: average with rounding, saturate
  logic [QB+1:0] sum;
  logic [QB-1:0] res;
  assign sum = (QB+2)'(rs) + (QB+2)'(rp) + (QB+2)'(2);
  assign res = QB'(sum >> 2);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      refl_o <= (res > QB'(16'hFFFF)) ? 16'hFFFF : 16'(res);
    end
  end
endmodule

FILE: rtl/conductor_fresnel_reflectance_unit.sv
// top level of the conductor fresnel reflectance unit
`timescale 1ns / 1ps
// usage:
// - in_if carries one transaction per hit: cosine (signed q1.14) and per
//   channel eta and extinction; out_if returns three q0.16 reflectances
// - one result transaction per input transaction, in order
// - the pipe holds three term stages, the divider's clamp stage, one
//   stage per quotient fraction bit and one output stage
// - throughput is one transaction per cycle while the receiver does not
//   stall, set by the fully pipelined dividers (one quotient bit per stage)
// - the whole pipe advances together; when the receiver stalls with a
//   valid result waiting, the pipe freezes and in_if.ready falls, so
//   nothing is lost or repeated; empty slots stay empty until it resumes
// - reset clears all valid bits; payload registers are not reset
// - nothing is kept between transactions
module conductor_fresnel_reflectance_unit #(
  parameter int unsigned IN_FRAC_BITS  = cfr_pkg::InFracDefault,
  parameter int unsigned OUT_FRAC_BITS = cfr_pkg::OutFracDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  cfr_in_if.sink    in_if,
  cfr_out_if.source out_if
);
  import cfr_pkg::*;
  localparam int unsigned Depth = OUT_FRAC_BITS + 6;

  logic [Depth-1:0] vld_q;
  logic             en;

  // pipe advances unless the last slot holds a result that is not taken
  assign en = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  // clamp cosine to 0..1
  logic [14:0] c;
  always_comb begin
    if (in_if.cos_incidence[15]) begin
      c = '0;
    end else if (in_if.cos_incidence > 16'sd16384) begin
      c = 15'd16384;
    end else begin
      c = in_if.cos_incidence[14:0];
    end
  end

  cfr_chan #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_red (
    .clk_i, .en_i(en), .c_i(c), .eta_i(in_if.eta_red), .ext_i(in_if.ext_red),
    .refl_o(out_if.refl_red));
  cfr_chan #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_grn (
    .clk_i, .en_i(en), .c_i(c), .eta_i(in_if.eta_green),
    .ext_i(in_if.ext_green), .refl_o(out_if.refl_green));
  cfr_chan #(.IN_FRAC_BITS(IN_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_blu (
    .clk_i, .en_i(en), .c_i(c), .eta_i(in_if.eta_blue),
    .ext_i(in_if.ext_blue), .refl_o(out_if.refl_blue));

  assign out_if.valid = vld_q[Depth-1];

  // a stalled result stays in place (checked on valid and the red channel)
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.refl_red))
    else $error("stalled result changed");
  // ready only drops when a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("ready low without stall");
  // accepted transaction enters the pipe
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> vld_q[0])
    else $error("transaction lost at entry");
endmodule
